### rtl/core/uf_rb_pkg.sv
// shared constants and types for the union-find store with rollback
`timescale 1ns / 1ps

package uf_rb_pkg;

  // node count and derived widths
  localparam int NODES       = 1024;
  localparam int NODE_W      = $clog2(NODES);
  localparam int SIZE_W      = NODE_W + 1;
  localparam int HIST_DEPTH  = NODES - 1;
  localparam int NODE_WORD_W = NODE_W + SIZE_W;
  localparam int HIST_W      = 2 * NODE_W;

  // stream widths
  localparam int FUNC_W      = 2;
  localparam int IN_TDATA_W  = ((2 * NODE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [SIZE_W-1:0] sz_t;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_UNITE = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_UNDO  = 2'd2,
    FUNC_ALT   = 2'd3
  } func_t;

endpackage

### rtl/core/uf_rb_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module uf_rb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/union_find_with_rollback.sv
// Disjoint-set store, union by size, no path compression, with undo of the
// last union. After reset a clearing pass over all NODES (1024) nodes sets
// every node to its own root of size 1; s_tready stays low meanwhile. One
// item is handled at a time. A root walk reads the node ram once per step; a
// node lies at most log2 NODES links below its root. Every item walks node_a
// and then node_b; unite writes the child link and the new top size after
// the walks (no write when the roots already match), undo reads the history
// and restores two node words before them (only a depth check on an empty
// history), and each item passes the accept state and waits before its
// result is loaded while the previous result still waits. The registered
// read of the node ram on every walk step sets the pace.
`timescale 1ns / 1ps

module union_find_with_rollback
  import uf_rb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // node_a, node_b, zero pad
  input  logic [FUNC_W-1:0]      s_tuser,   // func
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // same_set, merged, status, zero pad
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK_RD,
    S_WALK_CHK,
    S_LINK,
    S_LINK_TOP,
    S_POP_RD,
    S_POP_CHILD,
    S_POP_TOP,
    S_POP_CAPT,
    S_POP_WR_TOP,
    S_POP_WR_CHILD,
    S_DONE
  } state_t;

  state_t state;

  // item registers
  func_t func_r;
  node_t node_a_r;
  node_t node_b_r;

  // walk and link working registers
  node_t x_r;
  logic  walk_sel;
  node_t ra_r;
  node_t rb_r;
  sz_t   sa_r;
  sz_t   sb_r;
  node_t child_r;
  node_t top_r;
  node_t top_par_r;
  sz_t   sc_r;
  sz_t   st_r;
  logic  merged_r;
  logic  status_r;
  node_t clr_cnt;
  node_t undo_depth;

  // output register
  logic same_o;
  logic merged_o;
  logic status_o;

  // ram ports
  logic                   node_we;
  node_t                  node_waddr;
  logic [NODE_WORD_W-1:0] node_wdata;
  node_t                  node_raddr;
  logic [NODE_WORD_W-1:0] node_rdata;
  logic                   hist_we;
  logic [HIST_W-1:0]      hist_rdata;

  node_t rd_parent;
  sz_t   rd_size;
  node_t hist_child;
  node_t hist_top;
  logic  a_child;
  node_t link_child;
  node_t link_top;
  sz_t   link_sc;
  sz_t   link_st;
  logic  can_link;
  logic  out_free;

  assign rd_parent  = node_rdata[NODE_WORD_W-1:SIZE_W];
  assign rd_size    = node_rdata[SIZE_W-1:0];
  assign hist_child = hist_rdata[HIST_W-1:NODE_W];
  assign hist_top   = hist_rdata[NODE_W-1:0];

  // union by size: a's root goes under b's root unless a's set is larger
  assign a_child    = !(sa_r > sb_r);
  assign link_child = a_child ? ra_r : rb_r;
  assign link_top   = a_child ? rb_r : ra_r;
  assign link_sc    = a_child ? sa_r : sb_r;
  assign link_st    = a_child ? sb_r : sa_r;
  assign can_link   = (ra_r != rb_r) && (undo_depth != NODE_W'(HIST_DEPTH));

  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == S_IDLE);

  // node ram read address
  always_comb begin
    case (state)
      S_POP_CHILD: node_raddr = hist_child;
      S_POP_TOP:   node_raddr = top_r;
      default:     node_raddr = x_r;
    endcase
  end

  // node ram write port
  always_comb begin
    node_we    = 1'b0;
    node_waddr = x_r;
    node_wdata = {x_r, sz_t'(1)};
    case (state)
      S_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = clr_cnt;
        node_wdata = {clr_cnt, sz_t'(1)};
      end
      S_LINK: begin
        node_we    = can_link;
        node_waddr = link_child;
        node_wdata = {link_top, link_sc};
      end
      S_LINK_TOP: begin
        node_we    = 1'b1;
        node_waddr = top_r;
        node_wdata = {top_r, sz_t'(st_r + sc_r)};
      end
      S_POP_WR_TOP: begin
        node_we    = 1'b1;
        node_waddr = top_r;
        node_wdata = {top_par_r, sz_t'(st_r - sc_r)};
      end
      S_POP_WR_CHILD: begin
        node_we    = 1'b1;
        node_waddr = child_r;
        node_wdata = {child_r, sc_r};
      end
      default: begin
        node_we = 1'b0;
      end
    endcase
  end

  assign hist_we = (state == S_LINK) && can_link;

  uf_rb_ram #(
    .WIDTH (NODE_WORD_W),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  uf_rb_ram #(
    .WIDTH (HIST_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (undo_depth),
    .wdata ({link_child, link_top}),
    .raddr (undo_depth - 1'b1),
    .rdata (hist_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      undo_depth <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // result valid: set when a result is loaded, cleared when taken
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == NODE_W'(NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            func_r   <= func_t'(s_tuser);
            node_a_r <= s_tdata[NODE_W-1:0];
            node_b_r <= s_tdata[2*NODE_W-1:NODE_W];
            x_r      <= s_tdata[NODE_W-1:0];
            walk_sel <= 1'b0;
            merged_r <= 1'b0;
            status_r <= 1'b0;
            if (func_t'(s_tuser) == FUNC_UNDO) begin
              state <= S_POP_RD;
            end else begin
              state <= S_WALK_RD;
            end
          end
        end
        S_WALK_RD: begin
          state <= S_WALK_CHK;
        end
        // one step of a root walk
        S_WALK_CHK: begin
          if (rd_parent == x_r) begin
            if (!walk_sel) begin
              ra_r     <= x_r;
              sa_r     <= rd_size;
              x_r      <= node_b_r;
              walk_sel <= 1'b1;
              state    <= S_WALK_RD;
            end else begin
              rb_r <= x_r;
              sb_r <= rd_size;
              if (func_r == FUNC_UNITE) begin
                state <= S_LINK;
              end else begin
                state <= S_DONE;
              end
            end
          end else begin
            x_r   <= rd_parent;
            state <= S_WALK_RD;
          end
        end
        // hang the smaller root (a's on a tie) and push the history entry
        S_LINK: begin
          child_r <= link_child;
          top_r   <= link_top;
          sc_r    <= link_sc;
          st_r    <= link_st;
          if (can_link) begin
            merged_r   <= 1'b1;
            undo_depth <= undo_depth + 1'b1;
            state      <= S_LINK_TOP;
          end else begin
            state <= S_DONE;
          end
        end
        S_LINK_TOP: begin
          state <= S_DONE;
        end
        // undo: pop history, then restore sizes and the child link
        S_POP_RD: begin
          if (undo_depth == '0) begin
            status_r <= 1'b1;
            state    <= S_WALK_RD;
          end else begin
            undo_depth <= undo_depth - 1'b1;
            state      <= S_POP_CHILD;
          end
        end
        S_POP_CHILD: begin
          child_r <= hist_child;
          top_r   <= hist_top;
          state   <= S_POP_TOP;
        end
        S_POP_TOP: begin
          sc_r  <= rd_size;
          state <= S_POP_CAPT;
        end
        S_POP_CAPT: begin
          st_r      <= rd_size;
          top_par_r <= rd_parent;
          state     <= S_POP_WR_TOP;
        end
        S_POP_WR_TOP: begin
          state <= S_POP_WR_CHILD;
        end
        S_POP_WR_CHILD: begin
          merged_r <= 1'b1;
          state    <= S_WALK_RD;
        end
        // load the result once the output register is free
        S_DONE: begin
          if (out_free) begin
            merged_o <= merged_r;
            status_o <= status_r;
            if (func_r == FUNC_UNITE) begin
              same_o <= (ra_r == rb_r) || merged_r;
            end else begin
              same_o <= (ra_r == rb_r);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-3){1'b0}}, status_o, merged_o, same_o};

`ifndef SYNTH
  // history never grows past the largest possible forest
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    undo_depth <= NODE_W'(HIST_DEPTH))
    else $error("history depth out of range");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready after accept");

  // an empty-history undo never reports a split
  a_status_merged: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status_o |-> !merged_o)
    else $error("merged set with error status");

  // history depth changes only on a link or a pop
  a_depth_change: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (undo_depth != $past(undo_depth)) |->
      ($past(state) == S_LINK || $past(state) == S_POP_RD))
    else $error("history depth changed outside link or pop");
`endif

endmodule
